/* rtl/core/qlsf_pkg.sv */
// ----------------------------------------------------------------------------
// qlsf_pkg
// Shared types, codes and helper functions of the quadratic least-squares
// fit core: item structs, controller-to-datapath commands and status.
// ----------------------------------------------------------------------------
package qlsf_pkg;

    // input item
    typedef struct packed {
        logic [1:0]          operation;
        logic signed [11:0]  x_value;
        logic signed [15:0]  sample_y;
    } in_t;

    // result item
    typedef struct packed {
        logic [1:0]          status;
        logic signed [63:0]  fitted_y;
        logic signed [47:0]  coef_quadratic;
        logic signed [47:0]  coef_linear;
        logic signed [47:0]  coef_constant;
    } out_t;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;
    localparam logic [1:0] OP_EVAL  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_NOFIT    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // datapath command codes
    typedef logic [4:0] dp_op_t;
    localparam dp_op_t DP_NOP      = 5'd0;
    localparam dp_op_t DP_LATCH    = 5'd1;
    localparam dp_op_t DP_CLEAR    = 5'd2;
    localparam dp_op_t DP_FULL     = 5'd3;
    localparam dp_op_t DP_ACC1     = 5'd4;
    localparam dp_op_t DP_ACC2     = 5'd5;
    localparam dp_op_t DP_ACC3     = 5'd6;
    localparam dp_op_t DP_LOAD     = 5'd7;
    localparam dp_op_t DP_PIV_INIT = 5'd8;
    localparam dp_op_t DP_PIV_CMP  = 5'd9;
    localparam dp_op_t DP_SWAP     = 5'd10;
    localparam dp_op_t DP_RD_A     = 5'd11;
    localparam dp_op_t DP_RD_B     = 5'd12;
    localparam dp_op_t DP_MUL      = 5'd13;
    localparam dp_op_t DP_DIV      = 5'd14;
    localparam dp_op_t DP_SUB_WR   = 5'd15;
    localparam dp_op_t DP_ACC_SUB  = 5'd16;
    localparam dp_op_t DP_SINGULAR = 5'd17;
    localparam dp_op_t DP_VWR      = 5'd18;
    localparam dp_op_t DP_NOFIT    = 5'd19;
    localparam dp_op_t DP_EV_HOLD  = 5'd20;
    localparam dp_op_t DP_EV_FIN   = 5'd21;
    localparam dp_op_t DP_EMIT     = 5'd22;

    // multiplier operand selects
    typedef logic [1:0] msel_t;
    localparam msel_t MS_F_RB  = 2'd0;
    localparam msel_t MS_RB_V  = 2'd1;
    localparam msel_t MS_C2_XX = 2'd2;
    localparam msel_t MS_C1_X  = 2'd3;

    typedef struct packed {
        dp_op_t      op;
        logic [1:0]  row;
        logic [1:0]  col;
        msel_t       msel;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic fitted;
        logic rb_zero;
        logic mul_busy;
        logic div_busy;
    } dp_stat_t;

    // restoring divider steps for a 128-bit dividend
    localparam int DIV_STEPS = 128;

    // magnitude of a signed 64-bit value
    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (~v + 64'd1) : v;
    endfunction

    // signed value from sign and wide magnitude, saturated to 64 bits
    function automatic logic signed [63:0] from_mag(input logic neg, input logic [127:0] m);
        logic signed [63:0] r;
        if (m[127:63] != '0) begin
            r = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else if (neg) begin
            r = -$signed(m[63:0]);
        end else begin
            r = $signed(m[63:0]);
        end
        from_mag = r;
    endfunction

endpackage

/* rtl/core/qlsf_mul.sv */
// ----------------------------------------------------------------------------
// qlsf_mul
// Sign-magnitude 64 x 64 multiplier built from four 32 x 32 partial products,
// one per cycle, with optional fraction shift and 64-bit saturation.
// ----------------------------------------------------------------------------
module qlsf_mul #(
    parameter int FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic               shift_en,
    output logic               busy,
    output logic signed [63:0] res
);

    logic [63:0]        am_reg, bm_reg;
    logic               neg_reg, shift_reg, busy_reg;
    logic [2:0]         step_reg;
    logic [127:0]       acc_reg;
    logic signed [63:0] res_reg;
    logic [31:0]        ah, bh;
    logic [63:0]        pp;
    logic [127:0]       pp_w, sh_val;

    // partial product for the current half pair
    always_comb begin
        ah = step_reg[1] ? am_reg[63:32] : am_reg[31:0];
        bh = step_reg[0] ? bm_reg[63:32] : bm_reg[31:0];
        pp = ah * bh;
        case (step_reg[1:0])
            2'b00:   pp_w = {64'd0, pp};
            2'b11:   pp_w = {pp, 64'd0};
            default: pp_w = {32'd0, pp, 32'd0};
        endcase
        sh_val = shift_reg ? (acc_reg >> FRAC_BITS) : acc_reg;
    end

    // sequence the partial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            am_reg    <= qlsf_pkg::mag64(a);
            bm_reg    <= qlsf_pkg::mag64(b);
            neg_reg   <= a[63] ^ b[63];
            shift_reg <= shift_en;
            step_reg  <= 3'd0;
            acc_reg   <= '0;
            busy_reg  <= 1'b1;
        end else if (busy_reg) begin
            if (step_reg == 3'd4) begin
                res_reg  <= qlsf_pkg::from_mag(neg_reg, sh_val);
                busy_reg <= 1'b0;
            end else begin
                acc_reg  <= acc_reg + pp_w;
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule

/* rtl/core/qlsf_div.sv */
// ----------------------------------------------------------------------------
// qlsf_div
// Fixed-point divider: (|n| << FRAC_BITS) / |d| by restoring division, one
// quotient bit per cycle, signed and saturated to 64 bits. Zero divisor
// gives zero.
// ----------------------------------------------------------------------------
module qlsf_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               busy,
    output logic signed [63:0] res
);

    localparam int CNTW = $clog2(qlsf_pkg::DIV_STEPS);

    logic [127:0]       nq_reg;
    logic [63:0]        d_reg, r_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic               neg_reg, busy_reg, fin_reg;
    logic signed [63:0] res_reg;
    logic [64:0]        r2;
    logic               ge;

    // one restoring step
    always_comb begin
        r2 = {r_reg, nq_reg[127]};
        ge = (r2 >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else if (start) begin
            nq_reg   <= {64'd0, qlsf_pkg::mag64(a)} << FRAC_BITS;
            d_reg    <= qlsf_pkg::mag64(b);
            neg_reg  <= a[63] ^ b[63];
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
        end else if (busy_reg) begin
            if (fin_reg) begin
                res_reg  <= (d_reg == '0) ? 64'sd0 : qlsf_pkg::from_mag(neg_reg, nq_reg);
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
            end else begin
                r_reg   <= ge ? 64'(r2 - {1'b0, d_reg}) : r2[63:0];
                nq_reg  <= {nq_reg[126:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(qlsf_pkg::DIV_STEPS - 1)) begin
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule

/* rtl/core/qlsf_dp.sv */
// ----------------------------------------------------------------------------
// qlsf_dp
// Datapath: moment sums, augmented matrix with row permutation, pivot
// search, shared multiplier and divider, coefficients and result register.
// ----------------------------------------------------------------------------
module qlsf_dp #(
    parameter int MAX_SAMPLES = 64,
    parameter int FRAC_BITS   = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  qlsf_pkg::in_t       s_data,
    input  qlsf_pkg::dp_cmd_t   cmd,
    output qlsf_pkg::dp_stat_t  stat,
    output qlsf_pkg::out_t      m_data
);

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SXW   = 12 + CW;
    localparam int SX2W  = 24 + CW;
    localparam int SX3W  = 36 + CW;
    localparam int SX4W  = 48 + CW;
    localparam int SYW   = 16 + CW;
    localparam int SXYW  = 28 + CW;
    localparam int SX2YW = 40 + CW;
    localparam logic signed [63:0] FIX_LIM  = 64'sh7FFF_FFFF_FFFF_FFFF >>> FRAC_BITS;
    localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN  = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
    localparam logic signed [63:0] S48_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] S48_MIN  = -64'sh0000_8000_0000_0000;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = 65'(x) + 65'(y);
        if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
        else sat_add = s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = 65'(x) - 65'(y);
        if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
        else sat_sub = s[63:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > S48_MAX) sat48 = S48_MAX[47:0];
        else if (v < S48_MIN) sat48 = S48_MIN[47:0];
        else sat48 = v[47:0];
    endfunction

    function automatic logic signed [63:0] to_fixed(input logic signed [63:0] v);
        if (v > FIX_LIM) to_fixed = S64_MAX;
        else if (v < -FIX_LIM) to_fixed = S64_MIN;
        else to_fixed = v <<< FRAC_BITS;
    endfunction

    qlsf_pkg::in_t          in_reg;
    qlsf_pkg::out_t         out_reg;
    logic [CW-1:0]          count_reg;
    logic signed [SXW-1:0]  sum_x_reg;
    logic signed [SX2W-1:0] sum_x2_reg;
    logic signed [SX3W-1:0] sum_x3_reg;
    logic signed [SX4W-1:0] sum_x4_reg;
    logic signed [SYW-1:0]  sum_y_reg;
    logic signed [SXYW-1:0] sum_xy_reg;
    logic signed [SX2YW-1:0] sum_x2y_reg;
    logic signed [23:0]     x2_reg;
    logic signed [27:0]     xy_reg;
    logic signed [35:0]     x3_reg;
    logic signed [47:0]     x4_reg;
    logic signed [39:0]     x2y_reg;
    logic signed [63:0]     mat_reg [0:11];
    logic [1:0]             perm_reg [0:2];
    logic [1:0]             piv_row_reg;
    logic [63:0]            piv_mag_reg;
    logic signed [63:0]     ra_reg, rb_reg, fy_reg;
    logic signed [47:0]     coef_reg [0:2];
    logic                   fit_reg;
    logic [1:0]             status_reg;

    logic signed [11:0]     x_s;
    logic signed [15:0]     y_s;
    logic [3:0]             addr;
    logic signed [63:0]     rd_data, ld_src;
    logic [63:0]            rd_mag;
    logic signed [63:0]     mul_a, mul_b, mul_res, div_res;
    logic                   mul_shift, mul_busy, div_busy;
    logic [2:0]             pow_idx;

    assign x_s     = in_reg.x_value;
    assign y_s     = in_reg.sample_y;
    assign addr    = {perm_reg[cmd.row], cmd.col};
    assign rd_data = mat_reg[addr];
    assign rd_mag  = qlsf_pkg::mag64(rd_data);
    assign pow_idx = {1'b0, cmd.row} + {1'b0, cmd.col};

    // matrix load source
    always_comb begin
        ld_src = '0;
        if (cmd.col == 2'd3) begin
            case (cmd.row)
                2'd0:    ld_src = 64'(sum_y_reg);
                2'd1:    ld_src = 64'(sum_xy_reg);
                default: ld_src = 64'(sum_x2y_reg);
            endcase
        end else begin
            case (pow_idx)
                3'd0:    ld_src = $signed(64'(count_reg));
                3'd1:    ld_src = 64'(sum_x_reg);
                3'd2:    ld_src = 64'(sum_x2_reg);
                3'd3:    ld_src = 64'(sum_x3_reg);
                default: ld_src = 64'(sum_x4_reg);
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        case (cmd.msel)
            qlsf_pkg::MS_F_RB: begin
                mul_a = div_res;
                mul_b = rb_reg;
                mul_shift = 1'b1;
            end
            qlsf_pkg::MS_RB_V: begin
                mul_a = rb_reg;
                mul_b = 64'(coef_reg[cmd.col]);
                mul_shift = 1'b1;
            end
            qlsf_pkg::MS_C2_XX: begin
                mul_a = 64'(coef_reg[2]);
                mul_b = 64'(x_s * x_s);
                mul_shift = 1'b0;
            end
            default: begin
                mul_a = 64'(coef_reg[1]);
                mul_b = 64'(x_s);
                mul_shift = 1'b0;
            end
        endcase
    end

    qlsf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == qlsf_pkg::DP_MUL),
        .a        (mul_a),
        .b        (mul_b),
        .shift_en (mul_shift),
        .busy     (mul_busy),
        .res      (mul_res)
    );

    qlsf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == qlsf_pkg::DP_DIV),
        .a       (ra_reg),
        .b       (rb_reg),
        .busy    (div_busy),
        .res     (div_res)
    );

    // command execution
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_x2_reg  <= '0;
            sum_x3_reg  <= '0;
            sum_x4_reg  <= '0;
            sum_y_reg   <= '0;
            sum_xy_reg  <= '0;
            sum_x2y_reg <= '0;
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            fit_reg     <= 1'b0;
            status_reg  <= qlsf_pkg::ST_OK;
            perm_reg[0] <= 2'd0;
            perm_reg[1] <= 2'd1;
            perm_reg[2] <= 2'd2;
        end else begin
            unique case (cmd.op)
                qlsf_pkg::DP_LATCH: begin
                    in_reg     <= s_data;
                    status_reg <= qlsf_pkg::ST_OK;
                    fy_reg     <= '0;
                end
                qlsf_pkg::DP_CLEAR: begin
                    count_reg   <= '0;
                    sum_x_reg   <= '0;
                    sum_x2_reg  <= '0;
                    sum_x3_reg  <= '0;
                    sum_x4_reg  <= '0;
                    sum_y_reg   <= '0;
                    sum_xy_reg  <= '0;
                    sum_x2y_reg <= '0;
                end
                qlsf_pkg::DP_FULL:  status_reg <= qlsf_pkg::ST_FULL;
                qlsf_pkg::DP_NOFIT: status_reg <= qlsf_pkg::ST_NOFIT;
                qlsf_pkg::DP_ACC1: begin
                    x2_reg <= 24'(x_s * x_s);
                    xy_reg <= 28'(x_s * y_s);
                end
                qlsf_pkg::DP_ACC2: begin
                    x3_reg  <= 36'(x2_reg * x_s);
                    x4_reg  <= 48'(x2_reg * x2_reg);
                    x2y_reg <= 40'(x2_reg * y_s);
                end
                qlsf_pkg::DP_ACC3: begin
                    count_reg   <= count_reg + 1'b1;
                    sum_x_reg   <= sum_x_reg + SXW'(x_s);
                    sum_x2_reg  <= sum_x2_reg + SX2W'(x2_reg);
                    sum_x3_reg  <= sum_x3_reg + SX3W'(x3_reg);
                    sum_x4_reg  <= sum_x4_reg + SX4W'(x4_reg);
                    sum_y_reg   <= sum_y_reg + SYW'(y_s);
                    sum_xy_reg  <= sum_xy_reg + SXYW'(xy_reg);
                    sum_x2y_reg <= sum_x2y_reg + SX2YW'(x2y_reg);
                end
                qlsf_pkg::DP_LOAD: begin
                    mat_reg[{cmd.row, cmd.col}] <= to_fixed(ld_src);
                    perm_reg[0] <= 2'd0;
                    perm_reg[1] <= 2'd1;
                    perm_reg[2] <= 2'd2;
                end
                qlsf_pkg::DP_PIV_INIT: begin
                    piv_mag_reg <= rd_mag;
                    piv_row_reg <= cmd.row;
                end
                qlsf_pkg::DP_PIV_CMP: begin
                    if (rd_mag > piv_mag_reg) begin
                        piv_mag_reg <= rd_mag;
                        piv_row_reg <= cmd.row;
                    end
                end
                qlsf_pkg::DP_SWAP: begin
                    perm_reg[cmd.row]     <= perm_reg[piv_row_reg];
                    perm_reg[piv_row_reg] <= perm_reg[cmd.row];
                end
                qlsf_pkg::DP_RD_A:    ra_reg <= rd_data;
                qlsf_pkg::DP_RD_B:    rb_reg <= rd_data;
                qlsf_pkg::DP_SUB_WR:  mat_reg[addr] <= sat_sub(rd_data, mul_res);
                qlsf_pkg::DP_ACC_SUB: ra_reg <= sat_sub(ra_reg, mul_res);
                qlsf_pkg::DP_SINGULAR: begin
                    coef_reg[0] <= '0;
                    coef_reg[1] <= '0;
                    coef_reg[2] <= '0;
                    fit_reg     <= 1'b0;
                    status_reg  <= qlsf_pkg::ST_SINGULAR;
                end
                qlsf_pkg::DP_VWR: begin
                    coef_reg[cmd.row] <= sat48(div_res);
                    if (cmd.row == 2'd0) fit_reg <= 1'b1;
                end
                qlsf_pkg::DP_EV_HOLD: ra_reg <= mul_res;
                qlsf_pkg::DP_EV_FIN:  fy_reg <= sat_add(sat_add(ra_reg, mul_res),
                                                        64'(coef_reg[0]));
                qlsf_pkg::DP_EMIT: begin
                    out_reg.status         <= status_reg;
                    out_reg.fitted_y       <= fy_reg;
                    out_reg.coef_quadratic <= coef_reg[2];
                    out_reg.coef_linear    <= coef_reg[1];
                    out_reg.coef_constant  <= coef_reg[0];
                end
                default: ;
            endcase
        end
    end

    // status to the controller
    assign stat.full     = (count_reg == CW'(MAX_SAMPLES));
    assign stat.fitted   = fit_reg;
    assign stat.rb_zero  = (rb_reg == '0);
    assign stat.mul_busy = mul_busy;
    assign stat.div_busy = div_busy;
    assign m_data        = out_reg;

endmodule

/* rtl/core/qlsf_ctrl.sv */
// ----------------------------------------------------------------------------
// qlsf_ctrl
// Controller: item handshake, operation dispatch, and the elimination and
// back substitution sequence driven onto the datapath as commands.
// ----------------------------------------------------------------------------
module qlsf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    output logic                m_valid,
    input  logic                m_ready,
    output qlsf_pkg::dp_cmd_t   cmd,
    input  qlsf_pkg::dp_stat_t  stat
);

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_DISP  = 6'd1;
    localparam logic [5:0] S_ACC1  = 6'd2;
    localparam logic [5:0] S_ACC2  = 6'd3;
    localparam logic [5:0] S_ACC3  = 6'd4;
    localparam logic [5:0] S_LOAD  = 6'd5;
    localparam logic [5:0] S_PINIT = 6'd6;
    localparam logic [5:0] S_PCMP  = 6'd7;
    localparam logic [5:0] S_PSWAP = 6'd8;
    localparam logic [5:0] S_ZRD   = 6'd9;
    localparam logic [5:0] S_ZTST  = 6'd10;
    localparam logic [5:0] S_ELA   = 6'd11;
    localparam logic [5:0] S_ELB   = 6'd12;
    localparam logic [5:0] S_ELDIV = 6'd13;
    localparam logic [5:0] S_ELDW  = 6'd14;
    localparam logic [5:0] S_EJB   = 6'd15;
    localparam logic [5:0] S_EJM   = 6'd16;
    localparam logic [5:0] S_EJW   = 6'd17;
    localparam logic [5:0] S_EJA   = 6'd18;
    localparam logic [5:0] S_EJS   = 6'd19;
    localparam logic [5:0] S_BA    = 6'd20;
    localparam logic [5:0] S_BB    = 6'd21;
    localparam logic [5:0] S_BM    = 6'd22;
    localparam logic [5:0] S_BW    = 6'd23;
    localparam logic [5:0] S_BS    = 6'd24;
    localparam logic [5:0] S_BD    = 6'd25;
    localparam logic [5:0] S_BDIV  = 6'd26;
    localparam logic [5:0] S_BDW   = 6'd27;
    localparam logic [5:0] S_EV1   = 6'd28;
    localparam logic [5:0] S_EVW1  = 6'd29;
    localparam logic [5:0] S_EVH   = 6'd30;
    localparam logic [5:0] S_EV2   = 6'd31;
    localparam logic [5:0] S_EVW2  = 6'd32;
    localparam logic [5:0] S_EVF   = 6'd33;
    localparam logic [5:0] S_RESP  = 6'd34;

    logic [5:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // next state and command
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.op       = qlsf_pkg::DP_NOP;
        cmd.row      = i_reg;
        cmd.col      = j_reg;
        cmd.msel     = qlsf_pkg::MS_F_RB;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = qlsf_pkg::DP_LATCH;
                    op_next    = s_op;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (op_reg)
                    qlsf_pkg::OP_CLEAR: begin
                        cmd.op     = qlsf_pkg::DP_CLEAR;
                        state_next = S_RESP;
                    end
                    qlsf_pkg::OP_ADD: begin
                        if (stat.full) begin
                            cmd.op     = qlsf_pkg::DP_FULL;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_ACC1;
                        end
                    end
                    qlsf_pkg::OP_SOLVE: begin
                        k_next     = 2'd0;
                        j_next     = 2'd0;
                        state_next = S_LOAD;
                    end
                    default: begin
                        if (!stat.fitted) begin
                            cmd.op     = qlsf_pkg::DP_NOFIT;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_EV1;
                        end
                    end
                endcase
            end
            S_ACC1: begin
                cmd.op     = qlsf_pkg::DP_ACC1;
                state_next = S_ACC2;
            end
            S_ACC2: begin
                cmd.op     = qlsf_pkg::DP_ACC2;
                state_next = S_ACC3;
            end
            S_ACC3: begin
                cmd.op     = qlsf_pkg::DP_ACC3;
                state_next = S_RESP;
            end
            // fill the augmented matrix row by row
            S_LOAD: begin
                cmd.op  = qlsf_pkg::DP_LOAD;
                cmd.row = k_reg;
                if (j_reg == 2'd3) begin
                    j_next = 2'd0;
                    if (k_reg == 2'd2) begin
                        i_next     = 2'd0;
                        state_next = S_PINIT;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end else begin
                    j_next = j_reg + 2'd1;
                end
            end
            // pivot search on column i
            S_PINIT: begin
                cmd.op  = qlsf_pkg::DP_PIV_INIT;
                cmd.col = i_reg;
                if (i_reg == 2'd2) begin
                    state_next = S_PSWAP;
                end else begin
                    k_next     = i_reg + 2'd1;
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                cmd.op  = qlsf_pkg::DP_PIV_CMP;
                cmd.row = k_reg;
                cmd.col = i_reg;
                if (k_reg == 2'd2) state_next = S_PSWAP;
                else k_next = k_reg + 2'd1;
            end
            S_PSWAP: begin
                cmd.op     = qlsf_pkg::DP_SWAP;
                state_next = S_ZRD;
            end
            S_ZRD: begin
                cmd.op     = qlsf_pkg::DP_RD_B;
                cmd.col    = i_reg;
                state_next = S_ZTST;
            end
            S_ZTST: begin
                if (stat.rb_zero) begin
                    cmd.op     = qlsf_pkg::DP_SINGULAR;
                    state_next = S_RESP;
                end else if (i_reg == 2'd2) begin
                    state_next = S_BA;
                end else begin
                    k_next     = i_reg + 2'd1;
                    state_next = S_ELA;
                end
            end
            // elimination factor for row k
            S_ELA: begin
                cmd.op     = qlsf_pkg::DP_RD_A;
                cmd.row    = k_reg;
                cmd.col    = i_reg;
                state_next = S_ELB;
            end
            S_ELB: begin
                cmd.op     = qlsf_pkg::DP_RD_B;
                cmd.col    = i_reg;
                state_next = S_ELDIV;
            end
            S_ELDIV: begin
                cmd.op     = qlsf_pkg::DP_DIV;
                state_next = S_ELDW;
            end
            S_ELDW: begin
                if (!stat.div_busy) begin
                    j_next     = i_reg;
                    state_next = S_EJB;
                end
            end
            // row update a[k][j] -= f * a[i][j]
            S_EJB: begin
                cmd.op     = qlsf_pkg::DP_RD_B;
                state_next = S_EJM;
            end
            S_EJM: begin
                cmd.op     = qlsf_pkg::DP_MUL;
                cmd.msel   = qlsf_pkg::MS_F_RB;
                state_next = S_EJW;
            end
            S_EJW: begin
                if (!stat.mul_busy) state_next = S_EJS;
            end
            S_EJA: begin
                state_next = S_EJS;
            end
            S_EJS: begin
                cmd.op  = qlsf_pkg::DP_SUB_WR;
                cmd.row = k_reg;
                if (j_reg == 2'd3) begin
                    if (k_reg == 2'd2) begin
                        i_next     = i_reg + 2'd1;
                        state_next = S_PINIT;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_ELA;
                    end
                end else begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_EJB;
                end
            end
            // back substitution for unknown i
            S_BA: begin
                cmd.op  = qlsf_pkg::DP_RD_A;
                cmd.col = 2'd3;
                if (i_reg == 2'd2) begin
                    state_next = S_BD;
                end else begin
                    j_next     = i_reg + 2'd1;
                    state_next = S_BB;
                end
            end
            S_BB: begin
                cmd.op     = qlsf_pkg::DP_RD_B;
                state_next = S_BM;
            end
            S_BM: begin
                cmd.op     = qlsf_pkg::DP_MUL;
                cmd.msel   = qlsf_pkg::MS_RB_V;
                state_next = S_BW;
            end
            S_BW: begin
                if (!stat.mul_busy) state_next = S_BS;
            end
            S_BS: begin
                cmd.op = qlsf_pkg::DP_ACC_SUB;
                if (j_reg == 2'd2) begin
                    state_next = S_BD;
                end else begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_BB;
                end
            end
            S_BD: begin
                cmd.op     = qlsf_pkg::DP_RD_B;
                cmd.col    = i_reg;
                state_next = S_BDIV;
            end
            S_BDIV: begin
                cmd.op     = qlsf_pkg::DP_DIV;
                state_next = S_BDW;
            end
            S_BDW: begin
                if (!stat.div_busy) begin
                    cmd.op = qlsf_pkg::DP_VWR;
                    if (i_reg == 2'd0) begin
                        state_next = S_RESP;
                    end else begin
                        i_next     = i_reg - 2'd1;
                        state_next = S_BA;
                    end
                end
            end
            // evaluation a*x^2 + b*x + c
            S_EV1: begin
                cmd.op     = qlsf_pkg::DP_MUL;
                cmd.msel   = qlsf_pkg::MS_C2_XX;
                state_next = S_EVW1;
            end
            S_EVW1: begin
                if (!stat.mul_busy) state_next = S_EVH;
            end
            S_EVH: begin
                cmd.op     = qlsf_pkg::DP_EV_HOLD;
                state_next = S_EV2;
            end
            S_EV2: begin
                cmd.op     = qlsf_pkg::DP_MUL;
                cmd.msel   = qlsf_pkg::MS_C1_X;
                state_next = S_EVW2;
            end
            S_EVW2: begin
                if (!stat.mul_busy) state_next = S_EVF;
            end
            S_EVF: begin
                cmd.op     = qlsf_pkg::DP_EV_FIN;
                state_next = S_RESP;
            end
            // hand the result to the output register
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = qlsf_pkg::DP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            op_reg      <= qlsf_pkg::OP_CLEAR;
            i_reg       <= 2'd0;
            k_reg       <= 2'd0;
            j_reg       <= 2'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
        end
    end

endmodule

/* rtl/core/quadratic_least_squares_fit_core.sv */
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit_core
// Quadratic least-squares fit y = a*x^2 + b*x + c in signed fixed point.
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_data carry one item: clear sums, add sample (x, y),
//   solve the fit, or evaluate the fit at x. m_valid/m_ready/m_data return
//   one result per item: status, fitted value and the current coefficients.
//   one item is worked at a time; s_ready is high only while idle.
//   a solve without a singular pivot runs six restoring divisions and
//   fourteen shared multiplications; a refused or unfitted item goes
//   straight from dispatch to the response.
//   the next item is accepted while a result still waits in the output
//   register; a stalled receiver holds the core only when a second result
//   is ready to be written.
//   reset (aresetn low, synchronous) clears sums, count, coefficients and
//   the fitted flag; the matrix is loaded at the start of every solve.
// ----------------------------------------------------------------------------
module quadratic_least_squares_fit_core #(
    parameter int MAX_SAMPLES = 64,
    parameter int FRAC_BITS   = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  qlsf_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output qlsf_pkg::out_t  m_data
);

    qlsf_pkg::dp_cmd_t  cmd;
    qlsf_pkg::dp_stat_t stat;

    qlsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_data.operation),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    qlsf_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic least-squares fit core: a local
// fixed-point model predicts every result, directed and random item streams
// exercise accumulation, solve, evaluate, capacity and singular cases.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSAMP  = 64;
    localparam int FB     = 24;
    localparam longint LIMIT = 3000000;
    localparam logic signed [63:0] S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64MIN = 64'sh8000_0000_0000_0000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    qlsf_pkg::in_t    s_data;
    logic             m_valid;
    logic             m_ready;
    qlsf_pkg::out_t   m_data;

    // fit model state
    int                 n_pts;
    logic signed [63:0] mx, mx2, mx3, mx4, my, mxy, mx2y;
    logic signed [63:0] coef [3];
    logic               have_fit;

    qlsf_pkg::out_t expected_q [$];
    int     errors;
    longint cycles;
    bit     hold_off;
    bit     calm;

    quadratic_least_squares_fit_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // fixed-point helpers
    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic signed [63:0] sat_from(input bit neg, input logic [127:0] m);
        if (neg) return (m > 128'h8000_0000_0000_0000) ? S64MIN : -$signed(m[63:0]);
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? S64MAX : $signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int s);
        logic [127:0] p;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> s;
        return sat_from(a[63] != b[63], p);
    endfunction

    function automatic logic signed [63:0] fdiv(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [127:0] q;
        if (b == 0) return 0;
        q = ({64'd0, magn(a)} << FB) / {64'd0, magn(b)};
        return sat_from(a[63] != b[63], q);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] r;
        r = 65'(a) + 65'(b);
        if (r > 65'(S64MAX)) return S64MAX;
        if (r < 65'(S64MIN)) return S64MIN;
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] r;
        r = 65'(a) - 65'(b);
        if (r > 65'(S64MAX)) return S64MAX;
        if (r < 65'(S64MIN)) return S64MIN;
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] clip48(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic logic signed [63:0] scale_up(input logic signed [63:0] v);
        if (v > (S64MAX >>> FB)) return S64MAX;
        if (v < -(S64MAX >>> FB)) return S64MIN;
        return v <<< FB;
    endfunction

    // gaussian elimination on the normal equations; returns status
    function automatic logic [1:0] solve_fit();
        logic signed [63:0] a [3][4];
        logic signed [63:0] v [3];
        logic signed [63:0] t, f, acc;
        int best;
        a[0][0] = scale_up(n_pts); a[0][1] = scale_up(mx);  a[0][2] = scale_up(mx2);
        a[0][3] = scale_up(my);
        a[1][0] = scale_up(mx);    a[1][1] = scale_up(mx2); a[1][2] = scale_up(mx3);
        a[1][3] = scale_up(mxy);
        a[2][0] = scale_up(mx2);   a[2][1] = scale_up(mx3); a[2][2] = scale_up(mx4);
        a[2][3] = scale_up(mx2y);
        for (int i = 0; i < 3; i++) begin
            best = i;
            for (int k = i + 1; k < 3; k++)
                if (magn(a[k][i]) > magn(a[best][i])) best = k;
            if (best != i)
                for (int j = 0; j < 4; j++) begin
                    t = a[i][j]; a[i][j] = a[best][j]; a[best][j] = t;
                end
            if (a[i][i] == 0) begin
                have_fit = 1'b0;
                coef[0] = 0; coef[1] = 0; coef[2] = 0;
                return qlsf_pkg::ST_SINGULAR;
            end
            for (int k = i + 1; k < 3; k++) begin
                f = fdiv(a[k][i], a[i][i]);
                for (int j = i; j < 4; j++) a[k][j] = ssub(a[k][j], fmul(f, a[i][j], FB));
            end
        end
        for (int i = 2; i >= 0; i--) begin
            acc = a[i][3];
            for (int j = i + 1; j < 3; j++) acc = ssub(acc, fmul(a[i][j], v[j], FB));
            v[i] = clip48(fdiv(acc, a[i][i]));
        end
        coef[0] = v[2]; coef[1] = v[1]; coef[2] = v[0];
        have_fit = 1'b1;
        return qlsf_pkg::ST_OK;
    endfunction

    // predict the result of one item
    function automatic qlsf_pkg::out_t predict_fit(input qlsf_pkg::in_t it);
        qlsf_pkg::out_t r;
        logic signed [63:0] x, y, x2;
        x = it.x_value; y = it.sample_y; x2 = x * x;
        r = '0;
        r.status = qlsf_pkg::ST_OK;
        case (it.operation)
            qlsf_pkg::OP_CLEAR: begin
                n_pts = 0; mx = 0; mx2 = 0; mx3 = 0; mx4 = 0; my = 0; mxy = 0; mx2y = 0;
            end
            qlsf_pkg::OP_ADD: begin
                if (n_pts >= NSAMP) r.status = qlsf_pkg::ST_FULL;
                else begin
                    n_pts++; mx += x; mx2 += x2; mx3 += x2 * x; mx4 += x2 * x2;
                    my += y; mxy += x * y; mx2y += x2 * y;
                end
            end
            qlsf_pkg::OP_SOLVE: r.status = solve_fit();
            default: begin
                if (!have_fit) r.status = qlsf_pkg::ST_NOFIT;
                else r.fitted_y = sadd(sadd(fmul(coef[0], x2, 0), fmul(coef[1], x, 0)),
                                       coef[2]);
            end
        endcase
        r.coef_quadratic = coef[0][47:0];
        r.coef_linear    = coef[1][47:0];
        r.coef_constant  = coef[2][47:0];
        return r;
    endfunction

    // send one item, random idle before it unless calm; valid stays up until the next
    // idle slot or the end of the stream
    task automatic send_item(input logic [1:0] op, input logic signed [11:0] x,
                             input logic signed [15:0] y);
        qlsf_pkg::in_t it;
        it.operation = op; it.x_value = x; it.sample_y = y;
        if (!calm)
            while ($urandom_range(99) < 18) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(predict_fit(it));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // check results
    always @(posedge aclk) begin
        qlsf_pkg::out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_data.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, m_data.status);
                    errors++;
                end
                if (m_data.fitted_y !== e.fitted_y) begin
                    $display("%0t: fitted_y exp %0d got %0d", $time, e.fitted_y,
                             m_data.fitted_y);
                    errors++;
                end
                if (m_data.coef_quadratic !== e.coef_quadratic) begin
                    $display("%0t: coef_quadratic exp %0d got %0d", $time,
                             e.coef_quadratic, m_data.coef_quadratic);
                    errors++;
                end
                if (m_data.coef_linear !== e.coef_linear) begin
                    $display("%0t: coef_linear exp %0d got %0d", $time,
                             e.coef_linear, m_data.coef_linear);
                    errors++;
                end
                if (m_data.coef_constant !== e.coef_constant) begin
                    $display("%0t: coef_constant exp %0d got %0d", $time,
                             e.coef_constant, m_data.coef_constant);
                    errors++;
                end
            end
        end
    end

    // receiver ready with random stalls and a long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // random sample set then solve and queries
    task automatic fit_round(input int npts, input int xr);
        send_item(qlsf_pkg::OP_CLEAR, 12'($urandom), 16'($urandom));
        for (int i = 0; i < npts; i++)
            send_item(qlsf_pkg::OP_ADD, 12'($urandom_range(2 * xr) - xr), 16'($urandom));
        send_item(qlsf_pkg::OP_SOLVE, 12'($urandom), 16'($urandom));
        repeat ($urandom_range(6, 2))
            send_item(qlsf_pkg::OP_EVAL, 12'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        send_item(qlsf_pkg::OP_EVAL, 12'sd5, 16'sd0);
        send_item(qlsf_pkg::OP_SOLVE, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_EVAL, 12'sd5, 16'sd0);
        send_item(qlsf_pkg::OP_ADD, -12'sd2048, -16'sd32768);
        send_item(qlsf_pkg::OP_ADD, 12'sd2047, 16'sd32767);
        send_item(qlsf_pkg::OP_ADD, 12'sd0, 16'sd100);
        send_item(qlsf_pkg::OP_SOLVE, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_EVAL, -12'sd2048, 16'sd0);
        send_item(qlsf_pkg::OP_EVAL, 12'sd2047, -16'sd1);
        send_item(qlsf_pkg::OP_EVAL, 12'sd0, 16'sd0);
        // two equal x values give a singular system
        send_item(qlsf_pkg::OP_CLEAR, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_ADD, 12'sd3, 16'sd7);
        send_item(qlsf_pkg::OP_ADD, 12'sd3, 16'sd9);
        send_item(qlsf_pkg::OP_SOLVE, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_EVAL, 12'sd1, 16'sd0);
        // clear keeps the fit
        send_item(qlsf_pkg::OP_CLEAR, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_ADD, -12'sd1, 16'sd1);
        send_item(qlsf_pkg::OP_ADD, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_ADD, 12'sd1, 16'sd1);
        send_item(qlsf_pkg::OP_SOLVE, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_CLEAR, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_EVAL, 12'sd10, 16'sd0);
    endtask

    task automatic test_capacity();
        send_item(qlsf_pkg::OP_CLEAR, 12'sd0, 16'sd0);
        for (int i = 0; i < NSAMP + 3; i++)
            send_item(qlsf_pkg::OP_ADD, (i % 2) ? -12'sd2048 : 12'sd2047,
                      (i % 3) ? 16'sd32767 : -16'sd32768);
        send_item(qlsf_pkg::OP_SOLVE, 12'sd0, 16'sd0);
        send_item(qlsf_pkg::OP_EVAL, -12'sd2048, 16'sd0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(qlsf_pkg::OP_ADD, 12'($urandom), 16'($urandom));
        drain();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1000) begin
            if ($urandom_range(9) == 0) begin
                send_item(2'($urandom), 12'($urandom), 16'($urandom));
                sent++;
            end else begin
                int np;
                np = ($urandom_range(9) == 0) ? $urandom_range(NSAMP + 4)
                                              : $urandom_range(10, 3);
                fit_round(np, ($urandom_range(3) == 0) ? 2047 : $urandom_range(60, 1));
                sent += np + 5;
            end
            if (sent > 300 && sent < 420) calm = 1'b1;
            else calm = 1'b0;
        end
        drain();
    endtask

    initial begin
        errors   = 0;
        hold_off = 1'b0;
        calm     = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        n_pts = 0; mx = 0; mx2 = 0; mx3 = 0; mx4 = 0; my = 0; mxy = 0; mx2y = 0;
        coef[0] = 0; coef[1] = 0; coef[2] = 0;
        have_fit = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/qlsf_pkg.sv
rtl/core/qlsf_mul.sv
rtl/core/qlsf_div.sv
rtl/core/qlsf_dp.sv
rtl/core/qlsf_ctrl.sv
rtl/core/quadratic_least_squares_fit_core.sv
bench/tb.sv
